[design/indexed_list_insert_delete_macros.svh]
// ----------------------------------------------------------------------------
// indexed list assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, idle while reset is asserted
`define ILID_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ilid assertion failed");
// clocked check with no reset qualifier
`define ILID_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ilid assertion failed");
`else
`define ILID_ASSERT_RST(lbl, clk, rstn, prop)
`define ILID_ASSERT(lbl, clk, prop)
`endif

`endif

[design/ilid_pkg.sv]
// ----------------------------------------------------------------------------
// ilid_pkg
// shared sizes, request and status codes and the command word
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int REQ_W    = 2;
  localparam int POS_W    = 6;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // command queue between front and back, power of two deep
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_EMPTY = 2'd2,
    STS_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    op_e                    op;
    logic [POS_W-1:0]       pos;
    logic [VALUE_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } qwr_t;

endpackage

`default_nettype wire

[design/indexed_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// ordered list of up to DEPTH values with insert, delete, get and dump
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge with start high and busy low. It
// goes through a two-deep command queue into the list engine, which handles
// insert, delete and get with all entries shifting in parallel and gives one
// result for each. Dump gives one result per entry, one per cycle, so it holds
// the engine until the last entry is out (one result for an empty list). The
// engine pops the queued request when no dump is running and registers its
// result, which done_o then marks; a running dump holds it back. busy rises
// only when the queue is full, which happens while a dump is running.
// Results cannot be held off: each is on the ports for exactly the one cycle
// that done_o is high. No clearing pass is needed after reset.
`default_nettype none

module indexed_list_insert_delete (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ilid_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [ilid_pkg::POS_W-1:0]    position_i,
  input  wire logic [ilid_pkg::ITEM_W-1:0]   item_value_i,
  output logic                               done_o,
  output logic [ilid_pkg::STATUS_W-1:0]      status_o,
  output logic [ilid_pkg::ITEM_W-1:0]        read_value_o,
  output logic [ilid_pkg::ECOUNT_W-1:0]      entry_count_o,
  output logic                               last_o
);
  import ilid_pkg::*;

  qwr_t wr;
  cmd_t q_cmd;
  logic q_full, q_valid, pop;

  ilid_front u_front (
    .start_i      (start),
    .q_full_i     (q_full),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .busy_o       (busy),
    .wr_o         (wr)
  );

  ilid_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  ilid_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .pop_o         (pop),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

[design/ilid_queue.sv]
// ----------------------------------------------------------------------------
// ilid_queue
// short command queue between the front end and the list engine
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ilid_pkg::qwr_t wr_i,
  output logic               full_o,
  output logic               valid_o,
  output ilid_pkg::cmd_t     cmd_o,
  input  wire logic          pop_i
);
  import ilid_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == QCNT_W'(QDEPTH));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? QPTR_W'(wr_ptr_q + QPTR_W'(1)) : wr_ptr_q;
    rd_ptr_d = do_pop  ? QPTR_W'(rd_ptr_q + QPTR_W'(1)) : rd_ptr_q;
    fill_d   = fill_q;
    priority if (do_push && !do_pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

endmodule

`default_nettype wire

[design/ilid_front.sv]
// ----------------------------------------------------------------------------
// ilid_front
// request acceptance and decode into a command word for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_front (
  input  wire logic                         start_i,
  input  wire logic                         q_full_i,
  input  wire logic [ilid_pkg::REQ_W-1:0]   req_type_i,
  input  wire logic [ilid_pkg::POS_W-1:0]   position_i,
  input  wire logic [ilid_pkg::ITEM_W-1:0]  item_value_i,
  output logic                              busy_o,
  output ilid_pkg::qwr_t                    wr_o
);
  import ilid_pkg::*;

  assign busy_o        = q_full_i;
  assign wr_o.push     = start_i && !q_full_i;
  // request codes map one to one onto the op encoding
  assign wr_o.cmd.op   = op_e'(req_type_i);
  assign wr_o.cmd.pos  = position_i;
  // value only matters for insert, keep the store width
  assign wr_o.cmd.value = VALUE_WIDTH'(item_value_i);

endmodule

`default_nettype wire

[design/ilid_back.sv]
// ----------------------------------------------------------------------------
// ilid_back
// list engine: parallel shift store, count, dump sequencer, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_insert_delete_macros.svh"

module ilid_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire ilid_pkg::cmd_t                q_cmd_i,
  output logic                               pop_o,
  output logic                               done_o,
  output logic [ilid_pkg::STATUS_W-1:0]      status_o,
  output logic [ilid_pkg::ITEM_W-1:0]        read_value_o,
  output logic [ilid_pkg::ECOUNT_W-1:0]      entry_count_o,
  output logic                               last_o
);
  import ilid_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] store_q [DEPTH];

  logic                   res_valid_q, res_valid_d;
  logic                   last_q, last_d;
  status_e                status_q, status_d;
  logic [ITEM_W-1:0]      value_q, value_d;
  logic [CNT_W-1:0]       res_count_q;

  logic                   ins_en, del_en, pop;
  logic [CMP_W-1:0]       cnt_ext, pos_ext, ins_pos;
  logic [IDX_W-1:0]       rd_idx;
  logic [VALUE_WIDTH-1:0] rd_data;

  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(q_cmd_i.pos);
  // insert past the end becomes an append
  assign ins_pos = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;

  // single read port: a dump reads entry 0 then walks idx, otherwise the request position
  always_comb begin
    priority if (state_q == ST_DUMP) begin
      rd_idx = idx_q;
    end else if (q_cmd_i.op == OP_DUMP) begin
      rd_idx = '0;
    end else begin
      rd_idx = q_cmd_i.pos[IDX_W-1:0];
    end
  end
  assign rd_data = store_q[rd_idx];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pop         = 1'b0;
    ins_en      = 1'b0;
    del_en      = 1'b0;
    res_valid_d = 1'b0;
    last_d      = 1'b0;
    status_d    = STS_OK;
    value_d     = '0;
    unique case (state_q)
      ST_RUN: begin
        if (q_valid_i) begin
          pop         = 1'b1;
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          unique case (q_cmd_i.op)
            OP_INSERT: begin
              if (count_q >= CNT_W'(DEPTH)) begin
                status_d = STS_FULL;
              end else begin
                ins_en  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                status_d = STS_RANGE;
              end else begin
                del_en  = 1'b1;
                count_d = count_q - CNT_W'(1);
              end
            end
            OP_GET: begin
              if (pos_ext >= cnt_ext) begin
                status_d = STS_RANGE;
              end else begin
                value_d = ITEM_W'(rd_data);
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                status_d = STS_EMPTY;
              end else begin
                value_d = ITEM_W'(rd_data);
                if (count_q != CNT_W'(1)) begin
                  last_d  = 1'b0;
                  state_d = ST_DUMP;
                  idx_d   = IDX_W'(1);
                end
              end
            end
            default: begin
              status_d = STS_OK;
            end
          endcase
        end
      end
      ST_DUMP: begin
        res_valid_d = 1'b1;
        value_d     = ITEM_W'(rd_data);
        idx_d       = idx_q + IDX_W'(1);
        if (CNT_W'(idx_q) + CNT_W'(1) == count_q) begin
          last_d  = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    value_q     <= value_d;
    res_count_q <= count_d;
  end

  // entries above the insert position, or from the delete position up, all shift at once
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
    localparam logic [CMP_W-1:0] Slot = CMP_W'(gi);
    logic [VALUE_WIDTH-1:0] below, above;
    if (gi == 0) begin : g_first
      assign below = store_q[gi];
    end else begin : g_below
      assign below = store_q[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_top
      assign above = store_q[gi];
    end else begin : g_above
      assign above = store_q[gi+1];
    end
    always_ff @(posedge clk_i) begin
      if (ins_en) begin
        if (Slot > ins_pos) begin
          store_q[gi] <= below;
        end else if (Slot == ins_pos) begin
          store_q[gi] <= q_cmd_i.value;
        end
      end else if (del_en && (Slot >= pos_ext)) begin
        store_q[gi] <= above;
      end
    end
  end

  assign done_o        = res_valid_q;
  assign last_o        = last_q;
  assign status_o      = status_q;
  assign read_value_o  = value_q;
  assign entry_count_o = ECOUNT_W'(res_count_q);

  `ILID_ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))
  `ILID_ASSERT_RST(a_dump_idx, clk_i, rst_ni, (state_q == ST_DUMP) |-> (CNT_W'(idx_q) < count_q))
  `ILID_ASSERT_RST(a_no_pop_dump, clk_i, rst_ni, (state_q == ST_DUMP) |-> !pop)
  `ILID_ASSERT_RST(a_dump_strobes, clk_i, rst_ni, (state_q == ST_DUMP) |=> res_valid_q)
  `ILID_ASSERT_RST(a_last_strobe, clk_i, rst_ni, last_q |-> res_valid_q)

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the indexed list: requests go in through the
// start/busy handshake and every result word is checked against a shadow
// copy of the list kept in the bench
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ilid_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TRAIL_CYCLES   = 20;

  typedef struct packed {
    status_e              status;
    logic [ITEM_W-1:0]    value;
    logic [ECOUNT_W-1:0]  count;
    logic                 last;
  } list_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic [REQ_W-1:0]    req_type_i   = '0;
  logic [POS_W-1:0]    position_i   = '0;
  logic [ITEM_W-1:0]   item_value_i = '0;
  logic                busy;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [ITEM_W-1:0]   read_value_o;
  logic [ECOUNT_W-1:0] entry_count_o;
  logic                last_o;

  // shadow copy of the list
  logic [ITEM_W-1:0] shadow_list [DEPTH];
  int unsigned       shadow_count;

  list_result_t pending_results [$];
  list_result_t want;

  int errors;
  int words_sent;
  int results_checked;
  int op_seen [4];
  int full_rejects;
  int burst_left;
  int idle_cycles;
  bit back_to_back;

  indexed_list_insert_delete dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void push_result(status_e sts, logic [ITEM_W-1:0] val, logic lst);
    list_result_t r;
    r.status = sts;
    r.value  = val;
    r.count  = ECOUNT_W'(shadow_count);
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  // updates the shadow list and queues the result words a request causes
  function automatic void predict_list_request(op_e op, logic [POS_W-1:0] pos,
                                               logic [ITEM_W-1:0] val);
    int unsigned p;
    int unsigned i;
    p = 32'(pos);
    case (op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          full_rejects++;
          push_result(STS_FULL, '0, 1'b1);
        end else begin
          if (p > shadow_count) p = shadow_count;
          for (i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = val;
          shadow_count++;
          push_result(STS_OK, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (p >= shadow_count) begin
          push_result(STS_RANGE, '0, 1'b1);
        end else begin
          for (i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
          push_result(STS_OK, '0, 1'b1);
        end
      end
      OP_GET: begin
        if (p >= shadow_count) push_result(STS_RANGE, '0, 1'b1);
        else push_result(STS_OK, shadow_list[p], 1'b1);
      end
      default: begin
        if (shadow_count == 0) begin
          push_result(STS_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++)
            push_result(STS_OK, shadow_list[i], (i + 1 == shadow_count));
        end
      end
    endcase
  endfunction

  // sends one request word, with random gaps between bursts
  task automatic send_word(op_e op, logic [POS_W-1:0] pos, logic [ITEM_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = back_to_back ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    start        <= 1'b1;
    req_type_i   <= op;
    position_i   <= pos;
    item_value_i <= val;
    do @(posedge clk_i); while (busy);
    predict_list_request(op, pos, val);
    words_sent++;
    op_seen[op]++;
  endtask

  function automatic logic [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly in-range positions, now and then anything the field allows
  function automatic logic [POS_W-1:0] pick_position(bit for_insert);
    if (shadow_count == 0 || $urandom_range(0, 9) < 2) return POS_W'($urandom_range(0, 63));
    if (for_insert) return POS_W'($urandom_range(0, shadow_count));
    return POS_W'($urandom_range(0, shadow_count - 1));
  endfunction

  task automatic test_empty_list();
    send_word(OP_DUMP, 6'd0, '0);
    send_word(OP_DELETE, 6'd0, '1);
    send_word(OP_GET, 6'd0, '1);
    send_word(OP_DELETE, 6'd63, '0);
    send_word(OP_GET, 6'd63, '0);
  endtask

  task automatic test_edges();
    // past the end turns into an append
    send_word(OP_INSERT, 6'd63, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 6'd0, 32'h0000_0000);
    send_word(OP_INSERT, 6'd1, 32'h8000_0001);
    send_word(OP_INSERT, 6'd2, 32'hA5A5_A5A5);
    send_word(OP_GET, 6'd0, '1);
    send_word(OP_GET, 6'd3, '0);
    send_word(OP_GET, 6'd4, '0);
    send_word(OP_GET, 6'd63, '0);
    send_word(OP_DUMP, 6'd63, '1);
    send_word(OP_DELETE, 6'd1, '0);
    send_word(OP_DELETE, 6'd3, '0);
    send_word(OP_DELETE, 6'd2, '0);
    send_word(OP_DUMP, 6'd0, '0);
    send_word(OP_DELETE, 6'd0, '0);
    send_word(OP_DELETE, 6'd0, '0);
    send_word(OP_GET, 6'd0, '0);
  endtask

  task automatic test_fill_and_overflow();
    back_to_back = 1'b1;
    while (shadow_count < DEPTH) send_word(OP_INSERT, pick_position(1'b1), pick_value());
    back_to_back = 1'b0;
    repeat (3) send_word(OP_INSERT, POS_W'($urandom_range(0, 63)), pick_value());
    send_word(OP_DUMP, POS_W'($urandom_range(0, 63)), pick_value());
    send_word(OP_GET, 6'(DEPTH - 1), '0);
    send_word(OP_GET, 6'(DEPTH), '0);
    send_word(OP_DUMP, POS_W'($urandom_range(0, 63)), pick_value());
  endtask

  task automatic test_random_mix(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      back_to_back = (k >= n / 2 && k < n / 2 + 15);
      if (shadow_count < 3 && r < 60) r = 0;
      if (r < 35) send_word(OP_INSERT, pick_position(1'b1), pick_value());
      else if (r < 65) send_word(OP_DELETE, pick_position(1'b0), pick_value());
      else if (r < 88) send_word(OP_GET, pick_position(1'b0), pick_value());
      else send_word(OP_DUMP, POS_W'($urandom_range(0, 63)), pick_value());
    end
    back_to_back = 1'b0;
  endtask

  task automatic test_drain();
    while (shadow_count > 0) begin
      if ($urandom_range(0, 3) == 0) send_word(OP_GET, pick_position(1'b0), pick_value());
      send_word(OP_DELETE, POS_W'($urandom_range(0, shadow_count - 1)), pick_value());
    end
    send_word(OP_DUMP, POS_W'($urandom_range(0, 63)), pick_value());
  endtask

  // result checker: every result word is matched to the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d value %h count %0d last %0d",
               status_o, read_value_o, entry_count_o, last_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (read_value_o !== want.value) begin
          $error("read_value: expected %h, got %h", want.value, read_value_o);
          errors++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with neither a request nor a result moving
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without progress, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    shadow_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_edges();
    test_fill_and_overflow();
    test_random_mix(80);
    test_drain();
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TRAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d requests (insert %0d, delete %0d, get %0d, dump %0d)",
             words_sent, op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_GET],
             op_seen[OP_DUMP]);
    $display("checked %0d result words, %0d inserts rejected on a full list",
             results_checked, full_rejects);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/ilid_pkg.sv
design/ilid_queue.sv
design/ilid_front.sv
design/ilid_back.sv
design/indexed_list_insert_delete.sv
tb/tb_top.sv
